// File: design/rcsc_pkg.sv
// Package for the range cache with second-chance replacement.
// Holds field widths, the cache row layout, the controller state type and
// the command and status bundles shared by the controller and the datapath.
`default_nettype none

package rcsc_pkg;

    // Widths of the item fields.
    localparam int WID_W  = 2;
    localparam int DATA_W = 64;
    localparam int IDX_W  = 3;

    // One cache row: reference bit, range bounds and data handle.
    typedef struct packed {
        logic              ref_bit;
        logic [DATA_W-1:0] range_start;
        logic [DATA_W-1:0] range_end;
        logic [DATA_W-1:0] handle;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SWEEP_RD,
        S_SWEEP_CHK,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;  // input channel may take a transfer
        logic load;      // input transfer this cycle: latch the item
        logic clear_wr;  // write an empty row during the clearing pass
        logic scan_rd;   // read the next entry of the partition
        logic wr_hit;    // mark the matching entry referenced, record a hit
        logic sweep_rd;  // read the entry under the clock hand
        logic wr_clear;  // clear the reference bit under the hand, advance
        logic wr_fill;   // refill the victim under the hand, record a miss
        logic push;      // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // clearing pass writes its last row
        logic match;       // returned entry holds the timestamp
        logic chk_last;    // returned entry is the last of the partition
        logic ref_set;     // entry under the hand has its reference bit set
        logic sweep_done;  // every entry has been given its second chance
        logic out_free;    // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

// File: design/rcsc_if.sv
// Handshake channels of the range cache: lookup requests and results.
// Depends on rcsc_pkg for the field widths.
`default_nettype none

interface rcsc_in_if
    import rcsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WID_W-1:0]  worker_id;
    logic [DATA_W-1:0] timestamp;
    logic [DATA_W-1:0] new_slice_start;
    logic [DATA_W-1:0] new_slice_end;
    logic [DATA_W-1:0] new_handle;

    modport source (
        output valid, worker_id, timestamp, new_slice_start, new_slice_end, new_handle,
        input  ready
    );
    modport sink (
        input  valid, worker_id, timestamp, new_slice_start, new_slice_end, new_handle,
        output ready
    );
endinterface

interface rcsc_out_if
    import rcsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [IDX_W-1:0]  entry_index;
    logic [DATA_W-1:0] handle_out;

    modport source (
        output valid, hit, entry_index, handle_out,
        input  ready
    );
    modport sink (
        input  valid, hit, entry_index, handle_out,
        output ready
    );
endinterface

`default_nettype wire

// File: design/rcsc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rcsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic                                    i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/rcsc_ctrl.sv
// Controller of the range cache: clearing pass, lookup scan, clock sweep
// and hand-off to the output register. Depends on rcsc_pkg.
`default_nettype none

module rcsc_ctrl
    import rcsc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (i_sts.match) begin
                    n_state = S_DONE;
                end else if (i_sts.chk_last) begin
                    n_state = S_SWEEP_RD;
                end else begin
                    n_state = r_state;
                end
            end
            S_SWEEP_RD: begin
                n_state = S_SWEEP_CHK;
            end
            S_SWEEP_CHK: begin
                if (i_sts.ref_set && !i_sts.sweep_done) begin
                    n_state = S_SWEEP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                o_cmd.wr_hit  = i_sts.match;
            end
            S_SWEEP_RD: begin
                o_cmd.sweep_rd = 1'b1;
            end
            S_SWEEP_CHK: begin
                o_cmd.wr_clear = i_sts.ref_set && !i_sts.sweep_done;
                o_cmd.wr_fill  = !(i_sts.ref_set && !i_sts.sweep_done);
            end
            S_DONE: begin
                o_cmd.push = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/rcsc_dp.sv
// Datapath of the range cache: item registers, cache RAM, clock hands,
// range compare and the output register. Depends on rcsc_pkg, rcsc_if, rcsc_ram.
`default_nettype none

module rcsc_dp
    import rcsc_pkg::*;
#(
    parameter int ENTRIES = 8,
    parameter int WORKERS = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    output t_sts         o_sts,
    rcsc_in_if.sink      i_in,
    rcsc_out_if.source   o_out
);

    localparam int DEPTH = WORKERS * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW    = $clog2(ENTRIES + 1);
    localparam int WW    = (WORKERS > 1) ? $clog2(WORKERS) : 1;

    // Latched item.
    logic [WW-1:0]     r_worker;
    logic [DATA_W-1:0] r_ts;
    logic [DATA_W-1:0] r_new_start;
    logic [DATA_W-1:0] r_new_end;
    logic [DATA_W-1:0] r_new_handle;
    logic [WW-1:0]     w_worker;

    // Scan and sweep counters.
    logic [SW-1:0]     r_scan_idx;
    logic [HW-1:0]     r_chk_idx;
    logic              r_chk_vld;
    logic [SW-1:0]     r_steps;
    logic [AW-1:0]     r_clr_addr;
    logic [HW-1:0]     r_hand [WORKERS];
    logic [HW-1:0]     w_hand;
    logic [HW-1:0]     w_hand_nxt;
    logic              w_scan_issue;

    // Pending result and output register.
    logic              r_res_hit;
    logic [HW-1:0]     r_res_idx;
    logic [DATA_W-1:0] r_res_handle;
    logic              r_out_vld;
    logic              r_out_hit;
    logic [IDX_W-1:0]  r_out_idx;
    logic [DATA_W-1:0] r_out_handle;

    // RAM ports.
    logic [AW-1:0]     w_base;
    logic [AW-1:0]     w_hand_addr;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    t_row              w_wr_row;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    t_row              w_rd_row;

    // Worker id folded into the partitions that exist.
    always_comb begin
        w_worker = '0;
        for (int k = 0; k < 4; k++) begin
            if (i_in.worker_id == WID_W'(k)) begin
                w_worker = WW'(k % WORKERS);
            end
        end
    end

    // Input side.
    assign i_in.ready = i_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_worker     <= w_worker;
            r_ts         <= i_in.timestamp;
            r_new_start  <= i_in.new_slice_start;
            r_new_end    <= i_in.new_slice_end;
            r_new_handle <= i_in.new_handle;
        end
    end

    // Partition base and hand addresses.
    assign w_base      = AW'(r_worker * ENTRIES);
    assign w_hand      = r_hand[r_worker];
    assign w_hand_nxt  = (w_hand == HW'(ENTRIES - 1)) ? '0 : w_hand + 1'b1;
    assign w_hand_addr = w_base + AW'(w_hand);

    // Scan issues one read a cycle until the partition is exhausted.
    assign w_scan_issue = i_cmd.scan_rd && (r_scan_idx != SW'(ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_chk_vld  <= 1'b0;
            r_steps    <= '0;
        end else if (i_cmd.load) begin
            r_scan_idx <= '0;
            r_chk_vld  <= 1'b0;
            r_steps    <= '0;
        end else begin
            r_chk_vld <= w_scan_issue;
            if (w_scan_issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (i_cmd.wr_clear) begin
                r_steps <= r_steps + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_issue) begin
            r_chk_idx <= r_scan_idx[HW-1:0];
        end
    end

    // Clearing pass address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Clock hands, one per worker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORKERS; w++) begin
                r_hand[w] <= '0;
            end
        end else if (i_cmd.wr_clear || i_cmd.wr_fill) begin
            r_hand[r_worker] <= w_hand_nxt;
        end
    end

    // RAM read address: scan position or clock hand.
    assign w_rd_en   = w_scan_issue || i_cmd.sweep_rd;
    assign w_rd_addr = i_cmd.sweep_rd ? w_hand_addr : w_base + AW'(r_scan_idx[HW-1:0]);

    // RAM write selection.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_row  = '0;
        priority if (i_cmd.clear_wr) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
        end else if (i_cmd.wr_hit) begin
            w_wr_en          = 1'b1;
            w_wr_addr        = w_base + AW'(r_chk_idx);
            w_wr_row         = w_rd_row;
            w_wr_row.ref_bit = 1'b1;
        end else if (i_cmd.wr_clear) begin
            w_wr_en          = 1'b1;
            w_wr_addr        = w_hand_addr;
            w_wr_row         = w_rd_row;
            w_wr_row.ref_bit = 1'b0;
        end else if (i_cmd.wr_fill) begin
            w_wr_en              = 1'b1;
            w_wr_addr            = w_hand_addr;
            w_wr_row.ref_bit     = 1'b1;
            w_wr_row.range_start = r_new_start;
            w_wr_row.range_end   = r_new_end;
            w_wr_row.handle      = r_new_handle;
        end else begin
            w_wr_en = 1'b0;
        end
    end

    rcsc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_row),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_row)
    );

    // Pending result of the current lookup.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_hit) begin
            r_res_hit    <= 1'b1;
            r_res_idx    <= r_chk_idx;
            r_res_handle <= w_rd_row.handle;
        end else if (i_cmd.wr_fill) begin
            r_res_hit    <= 1'b0;
            r_res_idx    <= w_hand;
            r_res_handle <= r_new_handle;
        end
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_hit    <= r_res_hit;
            r_out_idx    <= IDX_W'(r_res_idx);
            r_out_handle <= r_res_handle;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.hit         = r_out_hit;
    assign o_out.entry_index = r_out_idx;
    assign o_out.handle_out  = r_out_handle;

    // Status to the controller.
    always_comb begin
        o_sts            = '0;
        o_sts.clear_last = (r_clr_addr == AW'(DEPTH - 1));
        o_sts.match      = r_chk_vld && (w_rd_row.range_start <= r_ts)
                           && (r_ts < w_rd_row.range_end);
        o_sts.chk_last   = r_chk_vld && (r_chk_idx == HW'(ENTRIES - 1));
        o_sts.ref_set    = w_rd_row.ref_bit;
        o_sts.sweep_done = (r_steps == SW'(ENTRIES));
        o_sts.out_free   = !r_out_vld || o_out.ready;
    end

endmodule

`default_nettype wire

// File: design/range_cache_second_chance_core.sv
// Top level of the range cache with second-chance (clock) replacement.
// Depends on rcsc_pkg, rcsc_if, rcsc_ctrl, rcsc_dp and rcsc_ram.
//
//   Channel   Dir  Modport  Payload
//   i_in      in   sink     worker_id, timestamp, new_slice_start,
//                           new_slice_end, new_handle
//   o_out     out  source   hit, entry_index, handle_out
//
// One lookup at a time. Entries are read from the cache RAM one per cycle.
// A hit ends the scan, and its result is pushed into the output register.
// A miss goes on to the clock sweep, in which the hand clears at most ENTRIES
// reference bits, each after its own RAM read, before it refills the victim.
// After reset a clearing pass writes all WORKERS*ENTRIES rows before the
// first input transfer is taken.
// A waiting result sits in the output register while the next lookup runs;
// that lookup holds its result only if the register is still occupied.
`default_nettype none

module range_cache_second_chance_core
    import rcsc_pkg::*;
#(
    parameter int ENTRIES = 8,
    parameter int WORKERS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcsc_in_if.sink    i_in,
    rcsc_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    rcsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rcsc_dp #(
        .ENTRIES (ENTRIES),
        .WORKERS (WORKERS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // No input transfer while the clearing pass is still writing rows.
    a_no_accept_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_wr |-> !(i_in.valid && i_in.ready))
        else $error("input transfer during clearing pass");

    // A result is only moved into an output register that is free.
    a_push_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_sts.out_free)
        else $error("result pushed over an unsent result");

    // The cache RAM has a single write port.
    a_one_writer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clear_wr, w_cmd.wr_hit, w_cmd.wr_clear, w_cmd.wr_fill}))
        else $error("conflicting cache writes");

    // A result pushed in one cycle is offered on the output in the next.
    a_push_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> o_out.valid)
        else $error("pushed result not offered");

endmodule

`default_nettype wire
